[src/bsc_pkg.sv]
// Package with the shared types and constants of the byte stuffing codec.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 2;

  // XOR pattern applied to an escaped byte.
  localparam logic [BYTE_W-1:0] XOR_MASK = 8'h20;

  localparam logic             MODE_RESET  = 1'b0;
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd254;
  localparam logic [BYTE_W-1:0] ESC_RESET   = 8'd253;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_DELIM = 2'd1,
    REG_ESC   = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // Number of results an input byte produces.
  typedef enum logic [1:0] {
    NRES_ZERO = 2'd0,
    NRES_ONE  = 2'd1,
    NRES_TWO  = 2'd2,
    NRES_BAD  = 2'd3
  } nres_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic              incomplete_escape;
  } result_t;

endpackage

`default_nettype wire

[src/bsc_stream_if.sv]
// Valid/ready stream interfaces for the input bytes and the coded results.
`timescale 1ns / 1ps
`default_nettype none

interface bsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsc_pkg::BYTE_W-1:0]  data_byte;
  logic                        block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface bsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsc_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_last;
  logic                        incomplete_escape;

  modport source (output valid, output out_byte, output out_last,
                  output incomplete_escape, input ready);
  modport sink   (input valid, input out_byte, input out_last,
                  input incomplete_escape, output ready);
endinterface

`default_nettype wire

[src/byte_stuffing_codec_unit.sv]
// Top level of the byte stuffing codec: input register, coding logic, result register.
//
// Usage: bytes enter on in_ch with a block_end mark on the last byte of a block
// and leave on out_ch as coded results. The mode register selects encoding
// (delimiter and escape bytes become the escape byte followed by the byte XOR
// 0x20) or decoding (an escape byte is dropped and the byte after it is XORed
// with 0x20). A decoded block that ends on an escape byte gives one result
// with incomplete_escape set, out_byte zero and out_last set.
// A byte passes through the input register and then the result register, which
// offers its result. A byte that yields one result leaves the input register as
// its result is loaded, so one transfer per cycle is sustained while the receiver
// takes results; a byte that is escaped while encoding yields two results and
// holds the input register until both are loaded, since the result register takes
// one result per cycle. A decoded escape byte yields no result and leaves without
// waiting for room. When the receiver stalls, the result register holds its
// transfer, the input register fills behind it and in_ch.ready falls; nothing is lost.
// Registers must be written over the APB port only while the block is idle; the
// block does not enforce this. Reset (synchronous, rst_n low) empties both registers,
// clears the pending escape and loads mode encode, delimiter 254 and escape 253.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffing_codec_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bsc_in_if.sink                            in_ch,
  bsc_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bsc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bsc_pkg::DATA_W-1:0]   pwdata,
  output logic      [bsc_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  // Configuration registers.
  bsc_pkg::mode_t                 mode_r;
  logic [bsc_pkg::BYTE_W-1:0]     delim_r;
  logic [bsc_pkg::BYTE_W-1:0]     esc_r;
  bsc_pkg::reg_idx_t              reg_idx;
  logic                           cfg_wr;

  // Input register and its progress.
  logic                           in_valid_r;
  logic [bsc_pkg::BYTE_W-1:0]     in_byte_r;
  logic                           in_last_r;
  logic                           phase_r;     // first of two results already sent
  logic                           esc_pend_r;
  logic                           esc_pend_nxt;

  // Result register.
  logic                           out_valid_r;
  bsc_pkg::result_t               out_r;

  // Coding logic outputs.
  bsc_pkg::nres_t                 nres;
  bsc_pkg::result_t               res0;
  bsc_pkg::result_t               res1;
  logic                           out_free;
  logic                           load;
  logic                           consume;
  logic                           in_xfer;

  assign pready  = 1'b1;
  assign reg_idx = bsc_pkg::reg_idx_t'(paddr[bsc_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      bsc_pkg::REG_MODE:  prdata[0] = mode_r;
      bsc_pkg::REG_DELIM: prdata[bsc_pkg::BYTE_W-1:0] = delim_r;
      bsc_pkg::REG_ESC:   prdata[bsc_pkg::BYTE_W-1:0] = esc_r;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bsc_pkg::mode_t'(bsc_pkg::MODE_RESET);
      delim_r <= bsc_pkg::DELIM_RESET;
      esc_r   <= bsc_pkg::ESC_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bsc_pkg::REG_MODE:  mode_r  <= bsc_pkg::mode_t'(pwdata[0]);
        bsc_pkg::REG_DELIM: delim_r <= pwdata[bsc_pkg::BYTE_W-1:0];
        bsc_pkg::REG_ESC:   esc_r   <= pwdata[bsc_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Coding of the byte in the input register. All results of one byte are
  // formed here; the phase bit picks which of two goes out.
  always_comb begin
    res0         = '{out_byte: in_byte_r, out_last: in_last_r, incomplete_escape: 1'b0};
    res1         = '{out_byte: in_byte_r ^ bsc_pkg::XOR_MASK, out_last: in_last_r,
                     incomplete_escape: 1'b0};
    nres         = bsc_pkg::NRES_ONE;
    esc_pend_nxt = 1'b0;
    if (mode_r == bsc_pkg::MODE_ENCODE) begin
      if (in_byte_r == delim_r || in_byte_r == esc_r) begin
        // Escape byte first, then the transformed byte carries the mark.
        res0 = '{out_byte: esc_r, out_last: 1'b0, incomplete_escape: 1'b0};
        nres = bsc_pkg::NRES_TWO;
      end
    end else if (esc_pend_r) begin
      res0 = res1;
    end else if (in_byte_r == esc_r) begin
      if (in_last_r) begin
        // The block ends while an escape is open.
        res0 = '{out_byte: '0, out_last: 1'b1, incomplete_escape: 1'b1};
      end else begin
        nres         = bsc_pkg::NRES_ZERO;
        esc_pend_nxt = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign load     = in_valid_r && (nres != bsc_pkg::NRES_ZERO) && out_free;
  assign consume  = in_valid_r &&
                    ((nres == bsc_pkg::NRES_ZERO) ||
                     (out_free && ((nres == bsc_pkg::NRES_ONE) || phase_r)));
  assign in_ch.ready = !in_valid_r || consume;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= 1'b0;
      esc_pend_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (consume) begin
        in_valid_r <= 1'b0;
      end
      if (consume) begin
        phase_r    <= 1'b0;
        esc_pend_r <= esc_pend_nxt;
      end else if (load) begin
        phase_r    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= phase_r ? res1 : res0;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.out_byte          = out_r.out_byte;
  assign out_ch.out_last          = out_r.out_last;
  assign out_ch.incomplete_escape = out_r.incomplete_escape;

  // The second half of an escaped byte only exists while its byte is held.
  a_phase_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> in_valid_r)
    else $error("phase set with empty input register");

  // The second result leaves as soon as the result register has room.
  a_phase_clears: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r && out_free |=> !phase_r)
    else $error("second result not sent when result register was free");

  // An open escape at a block end is reported as a final, empty result.
  a_incomplete_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.incomplete_escape |-> out_r.out_last && out_r.out_byte == '0)
    else $error("incomplete escape result malformed");

  // A pending escape is only set when a byte leaves the input register.
  a_pend_on_consume: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(esc_pend_r) |-> $past(consume))
    else $error("escape pending set without a consumed byte");

endmodule

`default_nettype wire

[verif/byte_stuffing_codec_unit_tb.sv]
// Self-checking testbench for the byte stuffing codec: directed cases, then random blocks.
`timescale 1ns / 1ps

module byte_stuffing_codec_unit_tb;
  import bsc_pkg::*;

  // An input transfer passes through the input and result registers. The drain time
  // lets a dropped escape byte leave before a register is written.
  localparam int DRAIN_CYCLES = 6;
  // Length of the long receiver hold-off that fills the block and stalls its input.
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1300;

  logic clk = 1'b0;
  logic rst_n;

  // APB-style register port.
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bsc_in_if  in_ch ();
  bsc_out_if out_ch ();

  byte_stuffing_codec_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the register file and of the decoder's escape flag. These are
  // written only by the monitor below, at the clock edge where the block itself
  // would see the write or the input transfer.
  mode_t       cur_mode;
  logic [7:0]  cur_delim;
  logic [7:0]  cur_esc;
  logic        esc_seen;

  // Coded results still to come, oldest first.
  result_t     expected_codes[$];
  int          fail_count = 0;

  // Knobs for the traffic shape, set by the tests.
  bit          src_gaps = 1'b0;
  bit          sink_stalls = 1'b0;
  bit          hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  // Register values lean toward the ends of the byte range.
  function automatic logic [7:0] pick_cfg_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 8'h00;
    if (roll < 40) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Input bytes hit the escape and delimiter values often, so that escape pairs,
  // doubled escapes and blocks ending on an escape are all frequent.
  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return cur_esc;
    if (roll < 30) return cur_delim;
    if (roll < 35) return cur_esc ^ XOR_MASK;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic result_t make_code(logic [7:0] b, logic last, logic incomplete);
    result_t r;
    r.out_byte = b;
    r.out_last = last;
    r.incomplete_escape = incomplete;
    return r;
  endfunction

  // Works out the results of one accepted input byte and queues them.
  function automatic void code_byte(logic [7:0] b, logic last);
    if (cur_mode == MODE_ENCODE) begin
      // The flag only matters while decoding; any encode step clears it.
      esc_seen = 1'b0;
      if (b == cur_delim || b == cur_esc) begin
        // A delimiter equal to the escape value is still escaped only once.
        expected_codes.push_back(make_code(cur_esc, 1'b0, 1'b0));
        expected_codes.push_back(make_code(b ^ XOR_MASK, last, 1'b0));
      end else begin
        expected_codes.push_back(make_code(b, last, 1'b0));
      end
    end else if (esc_seen) begin
      // The byte after an escape is unmasked, even when it is the escape value.
      esc_seen = 1'b0;
      expected_codes.push_back(make_code(b ^ XOR_MASK, last, 1'b0));
    end else if (b == cur_esc) begin
      if (last) begin
        // A block that ends on an escape byte gets a lone error result.
        expected_codes.push_back(make_code(8'h00, 1'b1, 1'b1));
      end else begin
        // The escape byte itself is dropped; out_last waits for a later byte.
        esc_seen = 1'b1;
      end
    end else begin
      expected_codes.push_back(make_code(b, last, 1'b0));
    end
  endfunction

  // One monitor for everything seen at the rising edge: register writes, input
  // transfers and result transfers. Keeping them in one block fixes their order.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      cur_mode  <= mode_t'(MODE_RESET);
      cur_delim <= DELIM_RESET;
      cur_esc   <= ESC_RESET;
      esc_seen  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MODE:  cur_mode = mode_t'(pwdata[0]);
          REG_DELIM: cur_delim = pwdata[7:0];
          REG_ESC:   cur_esc = pwdata[7:0];
          default: begin
            // Writes to an unused index are ignored by the block.
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        code_byte(in_ch.data_byte, in_ch.block_end);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte = out_ch.out_byte;
        got.out_last = out_ch.out_last;
        got.incomplete_escape = out_ch.incomplete_escape;
        if (expected_codes.size() == 0) begin
          $error("result %0h/%0b/%0b arrived with nothing expected",
                 got.out_byte, got.out_last, got.incomplete_escape);
          fail_count++;
        end else begin
          want = expected_codes.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            fail_count++;
          end
          if (got.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
            fail_count++;
          end
          if (got.incomplete_escape !== want.incomplete_escape) begin
            $error("incomplete_escape: expected %0b, got %0b",
                   want.incomplete_escape, got.incomplete_escape);
            fail_count++;
          end
        end
      end
    end
  end

  // Result receiver. It stalls at random when asked to, and once holds off for a
  // long counted stretch so that the result and input registers both fill up.
  initial begin
    int stall_left;
    int held;
    stall_left = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (sink_stalls && $urandom_range(0, 99) < 20) begin
        out_ch.ready = 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Offers one byte, after a random gap when gaps are on, and returns once the
  // transfer has taken place. valid stays high into the next call when there is
  // no gap, so back-to-back transfers happen.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = (src_gaps && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
    @(negedge clk);
    repeat (gap) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    in_ch.block_end = last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering bytes and waits until every expected result has come and a
  // byte that gives no result has had time to leave.
  task automatic drain_block();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Reads one register back and compares it with our copy.
  task automatic reg_check(reg_idx_t idx);
    logic [DATA_W-1:0] want;
    case (idx)
      REG_MODE:  want = DATA_W'(cur_mode);
      REG_DELIM: want = DATA_W'(cur_delim);
      default:   want = DATA_W'(cur_esc);
    endcase
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("%s: expected %0h, got %0h", idx.name(), want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(mode_t m, logic [7:0] delim, logic [7:0] esc);
    drain_block();
    reg_write(REG_MODE, DATA_W'(m));
    reg_write(REG_DELIM, DATA_W'(delim));
    reg_write(REG_ESC, DATA_W'(esc));
    reg_check(REG_MODE);
    reg_check(REG_DELIM);
    reg_check(REG_ESC);
  endtask

  // Reset values, then encoding with them: both byte extremes, the delimiter,
  // the escape value and the mask value itself.
  task automatic test_encode_defaults();
    reg_check(REG_MODE);
    reg_check(REG_DELIM);
    reg_check(REG_ESC);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFD, 1'b1);
    send_byte(8'h20, 1'b1);
  endtask

  // Decoding: a plain byte, an escape pair, an escaped escape value, a block
  // that ends on an escape byte, and an escape pair closing a block.
  task automatic test_decode_cases();
    configure(MODE_DECODE, 8'd254, 8'd253);
    send_byte(8'h41, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'hFD, 1'b1);
    send_byte(8'hFD, 1'b1);
    send_byte(8'hFD, 1'b0);
    send_byte(8'h5E, 1'b1);
  endtask

  // The escape flag survives a register write between the escape byte and the
  // byte after it, and is dropped by an encode step.
  task automatic test_mode_switch_mid_block();
    configure(MODE_DECODE, 8'd254, 8'd253);
    send_byte(8'hFD, 1'b0);
    drain_block();
    reg_write(REG_DELIM, DATA_W'(8'h7E));
    send_byte(8'h5E, 1'b0);
    send_byte(8'hFD, 1'b0);
    drain_block();
    reg_write(REG_MODE, DATA_W'(MODE_ENCODE));
    send_byte(8'h33, 1'b1);
    drain_block();
    reg_write(REG_MODE, DATA_W'(MODE_DECODE));
    send_byte(8'h13, 1'b1);
  endtask

  // Delimiter equal to the escape value, and a write to the unused index, which
  // the coding of the bytes sent after it shows to have changed nothing.
  task automatic test_equal_delim_escape();
    configure(MODE_ENCODE, 8'h7D, 8'h7D);
    reg_write(REG_NONE, '1);
    send_byte(8'h7D, 1'b0);
    send_byte(8'h5D, 1'b1);
    configure(MODE_DECODE, 8'h7D, 8'h7D);
    send_byte(8'h7D, 1'b0);
    send_byte(8'h5D, 1'b1);
  endtask

  // Register values at the ends of their range.
  task automatic test_extreme_values();
    configure(MODE_ENCODE, 8'h00, 8'hFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    configure(MODE_DECODE, 8'hFF, 8'h00);
    send_byte(8'h00, 1'b0);
    send_byte(8'h20, 1'b1);
  endtask

  // Random blocks in phases, each with its own register setting and traffic
  // shape. One phase holds the receiver off while the sender keeps going.
  task automatic test_random_traffic(int total);
    int sent;
    int phase;
    int phase_left;
    int blk_len;
    logic [7:0] delim;
    sent = 0;
    phase = 0;
    while (sent < total) begin
      delim = pick_cfg_byte();
      configure(mode_t'($urandom_range(0, 1)), delim,
                ($urandom_range(0, 5) == 0) ? delim : pick_cfg_byte());
      src_gaps = (phase % 4 == 0) || (phase % 4 == 2);
      sink_stalls = (phase % 4 == 0) || (phase % 4 == 3);
      if (phase == 2) begin
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        hold_req = 1'b1;
      end
      phase_left = $urandom_range(80, 160);
      while (phase_left > 0 && sent < total) begin
        blk_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
        for (int i = 0; i < blk_len; i++) begin
          send_byte(pick_byte(), i == blk_len - 1);
          sent++;
          phase_left--;
        end
      end
      phase++;
    end
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.block_end = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_encode_defaults();
    test_decode_cases();
    test_mode_switch_mid_block();
    test_equal_delim_escape();
    test_extreme_values();
    test_random_traffic(RANDOM_ITEMS);

    // Let the last results come out; anything still expected after that is lost.
    @(negedge clk);
    in_ch.valid = 1'b0;
    waited = 0;
    while (expected_codes.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_codes.size() != 0) begin
      $error("%0d expected results never arrived", expected_codes.size());
      fail_count++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** byte_stuffing_codec_unit: PASSED **");
    end else begin
      $display("** byte_stuffing_codec_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run.
  initial begin
    #2000000;
    $display("** byte_stuffing_codec_unit: FAILED **");
    $finish;
  end

endmodule
